### sv/urd_pkg.sv
// Shared types and constants for the unsigned restoring divider.
package urd_pkg;

	// Port word width; the result is carried internally at full width
	localparam int unsigned HALF_W = 64;
	localparam int unsigned FULL_W = 2 * HALF_W;

	typedef logic [FULL_W-1:0] full_t;

	// Per-stage control that travels alongside the payload
	typedef struct packed {
		logic valid;
		logic den_zero;
	} ctl_t;

endpackage

### sv/unsigned_restoring_divider.sv
// Top level of the pipelined unsigned restoring divider.
// Fully pipelined WIDTH-bit unsigned divider (WIDTH from 8 to 128, the low WIDTH
// bits of each 128-bit operand are used, higher result bits read as zero). busy
// stays low, so an item is taken on every cycle that start is high. Each item
// passes an input register, one stage per quotient bit (WIDTH stages, each a
// WIDTH+1-bit trial subtract) and an output register: its result is on the ports
// with done high for one cycle only. Results leave in the order items came in. A
// zero divisor gives a zero quotient and returns the dividend as the remainder.
module unsigned_restoring_divider #(
	parameter int unsigned WIDTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] dividend_high,
	input  logic [63:0] dividend_low,
	input  logic [63:0] divisor_high,
	input  logic [63:0] divisor_low,
	output logic        done,
	output logic [63:0] quotient_high,
	output logic [63:0] quotient_low,
	output logic [63:0] remainder_high,
	output logic [63:0] remainder_low
);

	localparam int unsigned LATENCY = WIDTH + 2;

	urd_pkg::full_t   dividend_full;
	urd_pkg::full_t   divisor_full;
	logic [WIDTH-1:0] dividend_w;
	logic [WIDTH-1:0] divisor_w;
	logic             accept;

	// Stage 0 is the input register, stage k has resolved k quotient bits
	urd_pkg::ctl_t    ctl_s [WIDTH+1];
	logic [WIDTH-1:0] rem_s [WIDTH+1];
	logic [WIDTH-1:0] dq_s  [WIDTH+1];
	logic [WIDTH-1:0] den_s [WIDTH+1];

	logic             done_q;
	urd_pkg::full_t   quotient_q;
	urd_pkg::full_t   remainder_q;

	// The pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Operand clipping to WIDTH bits
	always_comb begin
		dividend_full = {dividend_high, dividend_low};
		divisor_full  = {divisor_high, divisor_low};
		dividend_w    = dividend_full[WIDTH-1:0];
		divisor_w     = divisor_full[WIDTH-1:0];
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0].valid    <= accept;
			ctl_s[0].den_zero <= (divisor_w == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rem_s[0] <= '0;
			dq_s[0]  <= dividend_w;
			den_s[0] <= divisor_w;
		end
	end

	// One stage per quotient bit, most significant first
	for (genvar k = 0; k < WIDTH; k++) begin : g_stage
		urd_stage #(
			.WIDTH(WIDTH)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_s[k]),
			.rem_in (rem_s[k]),
			.dq_in  (dq_s[k]),
			.den_in (den_s[k]),
			.ctl_out(ctl_s[k+1]),
			.rem_out(rem_s[k+1]),
			.dq_out (dq_s[k+1]),
			.den_out(den_s[k+1])
		);
	end

	// Output register; a zero divisor forces the quotient to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_s[WIDTH].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s[WIDTH].valid) begin
			quotient_q  <= ctl_s[WIDTH].den_zero ? '0 : urd_pkg::full_t'(dq_s[WIDTH]);
			remainder_q <= urd_pkg::full_t'(rem_s[WIDTH]);
		end
	end

	assign done           = done_q;
	assign quotient_high  = quotient_q[urd_pkg::FULL_W-1:urd_pkg::HALF_W];
	assign quotient_low   = quotient_q[urd_pkg::HALF_W-1:0];
	assign remainder_high = remainder_q[urd_pkg::FULL_W-1:urd_pkg::HALF_W];
	assign remainder_low  = remainder_q[urd_pkg::HALF_W-1:0];

	// Every result strobe traces back to an accepted item at the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without matching item");

	// After the last stage the remainder is below a nonzero divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s[WIDTH].valid && !ctl_s[WIDTH].den_zero) |-> (rem_s[WIDTH] < den_s[WIDTH]))
		else $error("remainder not below divisor");

	// An item in the input register leads to a result at the output
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[0].valid |-> ##(WIDTH+1) done)
		else $error("item lost in pipeline");

endmodule

### sv/urd_stage.sv
// One pipeline stage of the restoring divider: resolves a single quotient bit.
module urd_stage #(
	parameter int unsigned WIDTH = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  urd_pkg::ctl_t        ctl_in,
	input  logic [WIDTH-1:0]     rem_in,
	input  logic [WIDTH-1:0]     dq_in,
	input  logic [WIDTH-1:0]     den_in,
	output urd_pkg::ctl_t        ctl_out,
	output logic [WIDTH-1:0]     rem_out,
	output logic [WIDTH-1:0]     dq_out,
	output logic [WIDTH-1:0]     den_out
);

	logic [WIDTH:0]   partial;
	logic [WIDTH+1:0] diff;
	logic             fits;
	logic [WIDTH-1:0] rem_next;

	// Shift the next dividend bit into the partial remainder, trial subtract
	always_comb begin
		partial  = {rem_in, dq_in[WIDTH-1]};
		diff     = {1'b0, partial} - {2'b00, den_in};
		fits     = ~diff[WIDTH+1];
		rem_next = fits ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
	end

	// Control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	// Payload register; dividend bits leave at the top, quotient bits enter below
	always_ff @(posedge clk) begin
		if (ctl_in.valid) begin
			rem_out <= rem_next;
			dq_out  <= {dq_in[WIDTH-2:0], fits};
			den_out <= den_in;
		end
	end

endmodule
